[hdl/ppu_pkg.sv]
// Shared types and constants for the palette pixel unpacker.
`default_nettype none

package ppu_pkg;

	// Palette size and the address width that follows from it.
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// Operation codes of an input transaction.
	localparam logic OP_FRAME_BYTE = 1'b0;
	localparam logic OP_PAL_WRITE  = 1'b1;

	// Pixel depth codes; everything from DEPTH_DIRECT up is direct color.
	localparam logic [2:0] DEPTH_1BPP   = 3'd0;
	localparam logic [2:0] DEPTH_2BPP   = 3'd1;
	localparam logic [2:0] DEPTH_4BPP   = 3'd2;
	localparam logic [2:0] DEPTH_8BPP   = 3'd3;
	localparam logic [2:0] DEPTH_DIRECT = 3'd4;

	// Register map.
	localparam logic REG_PIXEL_DEPTH = 1'b0;

	// Input transaction.
	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [15:0] palette_color;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [15:0] pixel_color;
		logic        last_of_byte;
	} out_t;

	// Control carried alongside a palette read into the result stage.
	typedef struct packed {
		logic        direct;
		logic        oob;
		logic        last;
		logic [15:0] direct_color;
	} pix_ctrl_t;

endpackage

`default_nettype wire

[hdl/palette_pixel_unpacker_unit.sv]
// Top level of the palette pixel unpacker: register port, issue, palette and result.
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid / in_ready  ppu_pkg::in_t  (op, byte, palette write)
//  out       output     out_valid/out_ready  ppu_pkg::out_t (pixel color, last flag)
//  apb       input      psel/penable/pready  pixel_depth_code at byte address 0
//
// A frame byte at 1, 2, 4 or 8 bits per pixel gives 8, 4, 2 or 1 pixels, one pixel per
// cycle while the result stage is not stalled, through the single palette read port; a
// palette write or a direct color byte gives at most one. An accepted transaction is
// registered in the issue stage, and its pixels then in the result stage.
// Reset clears the depth register to direct color and drops any held byte; the palette
// is not cleared and an entry holds nothing defined until written.
// A stalled output holds the result stage; the issue stage stalls behind it.
`default_nettype none

module palette_pixel_unpacker_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire ppu_pkg::in_t  in_data,
	output      logic          out_valid,
	input  wire logic          out_ready,
	output      ppu_pkg::out_t out_data,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output      logic [31:0]   prdata,
	output      logic          pready
);
	import ppu_pkg::*;

	logic [2:0]          depth_code_q;
	logic                reg_sel;
	logic                cfg_wr;
	logic                res_ready;
	logic                emit;
	pix_ctrl_t           emit_ctrl;
	logic                pal_we;
	logic [PAL_AW-1:0]   pal_waddr;
	logic [15:0]         pal_wdata;
	logic [PAL_AW-1:0]   pal_raddr;
	logic [15:0]         pal_rdata;

	// Register port: the word index is paddr[2].
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_PIXEL_DEPTH);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {29'd0, depth_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_code_q <= DEPTH_DIRECT;
		end else if (cfg_wr) begin
			depth_code_q <= pwdata[2:0];
		end
	end

	ppu_issue u_issue (
		.clk        (clk),
		.arst_n     (arst_n),
		.depth_code (depth_code_q),
		.cfg_wr     (cfg_wr),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.res_ready  (res_ready),
		.emit       (emit),
		.emit_ctrl  (emit_ctrl),
		.pal_we     (pal_we),
		.pal_waddr  (pal_waddr),
		.pal_wdata  (pal_wdata),
		.pal_raddr  (pal_raddr)
	);

	ppu_palette_ram u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (emit && res_ready),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	ppu_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.emit_ctrl (emit_ctrl),
		.res_ready (res_ready),
		.pal_rdata (pal_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[hdl/ppu_palette_ram.sv]
// Palette memory: one write port and one read port with registered read data.
`default_nettype none

module ppu_palette_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [ppu_pkg::PAL_AW-1:0] waddr,
	input  wire logic [15:0]               wdata,
	input  wire logic                      re,
	input  wire logic [ppu_pkg::PAL_AW-1:0] raddr,
	output      logic [15:0]               rdata
);
	import ppu_pkg::*;

	logic [15:0] mem [PALETTE_DEPTH];
	logic [15:0] rd_data_q;

	// A read of the address being written returns the old entry; the read register holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

`default_nettype wire

[hdl/ppu_issue.sv]
// Issue stage: holds one input transaction, walks its pixels and drives the palette.
`default_nettype none

module ppu_issue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [2:0]                 depth_code,
	input  wire logic                       cfg_wr,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire ppu_pkg::in_t               in_data,
	input  wire logic                       res_ready,
	output      logic                       emit,
	output      ppu_pkg::pix_ctrl_t         emit_ctrl,
	output      logic                       pal_we,
	output      logic [ppu_pkg::PAL_AW-1:0] pal_waddr,
	output      logic [15:0]                pal_wdata,
	output      logic [ppu_pkg::PAL_AW-1:0] pal_raddr
);
	import ppu_pkg::*;

	logic        valid_s1;
	in_t         item_s1;
	logic [2:0]  code_s1;
	logic [2:0]  pix_cnt_s1;
	logic [7:0]  held_high_q;
	logic        high_held_q;

	logic        is_write;
	logic        direct_mode;
	logic [2:0]  shift;
	logic [2:0]  last_idx;
	logic [7:0]  mask;
	logic [7:0]  idx;
	logic        last_step;
	logic        go;
	logic        done;
	logic        in_fire;

	// Decode of the held transaction; the depth is captured at acceptance.
	assign is_write    = (item_s1.op == OP_PAL_WRITE);
	assign direct_mode = (code_s1 >= DEPTH_DIRECT);
	assign shift       = 3'(pix_cnt_s1 << code_s1[1:0]);
	assign last_idx    = 3'(3'd7 >> code_s1[1:0]);

	always_comb begin
		case (code_s1)
			DEPTH_1BPP: mask = 8'h01;
			DEPTH_2BPP: mask = 8'h03;
			DEPTH_4BPP: mask = 8'h0f;
			DEPTH_8BPP: mask = 8'hff;
			default:    mask = 8'hff;
		endcase
	end

	assign idx = 8'(item_s1.data_byte >> shift) & mask;

	// A frame byte gives a pixel now unless it is the first half of a direct pair.
	assign emit      = valid_s1 && !is_write && (!direct_mode || high_held_q);
	assign go        = valid_s1 && (!emit || res_ready);
	assign last_step = is_write || direct_mode || (pix_cnt_s1 == last_idx);
	assign done      = go && last_step;
	assign in_ready  = !valid_s1 || done;
	assign in_fire   = in_valid && in_ready;

	assign emit_ctrl.direct       = direct_mode;
	assign emit_ctrl.oob          = (int'(idx) >= PALETTE_DEPTH);
	assign emit_ctrl.last         = last_step;
	assign emit_ctrl.direct_color = {held_high_q, item_s1.data_byte};

	// Palette port: writes outside the palette are dropped.
	assign pal_we    = go && is_write && (int'(item_s1.palette_index) < PALETTE_DEPTH);
	assign pal_waddr = item_s1.palette_index[PAL_AW-1:0];
	assign pal_wdata = item_s1.palette_color;
	assign pal_raddr = idx[PAL_AW-1:0];

	// Control state of the stage and its pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			pix_cnt_s1 <= 3'd0;
		end else if (in_fire) begin
			valid_s1   <= 1'b1;
			pix_cnt_s1 <= 3'd0;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			pix_cnt_s1 <= pix_cnt_s1 + 3'd1;
		end
	end

	// Transaction payload and the depth it is unpacked with.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
			code_s1 <= depth_code;
		end
	end

	// Direct mode pairing; a depth write drops a half pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_high_q <= 8'd0;
			high_held_q <= 1'b0;
		end else if (cfg_wr) begin
			high_held_q <= 1'b0;
		end else if (go && !is_write && direct_mode) begin
			if (!high_held_q) begin
				held_high_q <= item_s1.data_byte;
				high_held_q <= 1'b1;
			end else begin
				high_held_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/ppu_result.sv]
// Result stage: pairs registered palette data with its control and drives the output.
`default_nettype none

module ppu_result (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               emit,
	input  wire ppu_pkg::pix_ctrl_t emit_ctrl,
	output      logic               res_ready,
	input  wire logic [15:0]        pal_rdata,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      ppu_pkg::out_t      out_data
);
	import ppu_pkg::*;

	logic      valid_s2;
	pix_ctrl_t ctrl_s2;

	// The stage takes a new pixel when empty or when its pixel leaves.
	assign res_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && emit) begin
			ctrl_s2 <= emit_ctrl;
		end
	end

	// Color select: direct pair, out of range index, or palette entry.
	assign out_valid             = valid_s2;
	assign out_data.pixel_color  = ctrl_s2.direct ? ctrl_s2.direct_color :
	                               (ctrl_s2.oob ? 16'd0 : pal_rdata);
	assign out_data.last_of_byte = ctrl_s2.last;

endmodule

`default_nettype wire

[hdl/ppu_checker.sv]
// Port-level checks for the palette pixel unpacker and their binding to the top level.
`default_nettype none

module ppu_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire ppu_pkg::in_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire ppu_pkg::out_t out_data,
	input wire logic          psel,
	input wire logic          penable,
	input wire logic          pwrite,
	input wire logic [2:0]    paddr,
	input wire logic [31:0]   pwdata,
	input wire logic [31:0]   prdata,
	input wire logic          pready
);
	import ppu_pkg::*;

	// A stalled result transaction stays and keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result transaction changed while stalled");

	// Pixels of one byte leave back to back once the first one is taken.
	a_byte_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_byte |=> out_valid)
		else $error("gap inside the pixels of one byte");

	// A depth write reads back on the next cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_PIXEL_DEPTH)
		|=> (paddr[2] != REG_PIXEL_DEPTH) || (prdata[2:0] == $past(pwdata[2:0])))
		else $error("depth register did not take the written value");

	// A waiting input transaction stays and keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input transaction changed while waiting");

	// Nothing beyond the depth code reads back as set.
	a_cfg_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:3] == 29'd0)
		else $error("unused register bits read as set");

endmodule

bind palette_pixel_unpacker_unit ppu_checker u_ppu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);

`default_nettype wire

[dv/palette_pixel_unpacker_unit_tb.sv]
// Self-checking testbench for the palette pixel unpacker: directed rows, then random traffic.
`timescale 1ns / 1ps

module palette_pixel_unpacker_unit_tb;

	import ppu_pkg::*;

	// Kinds of rows in the directed stimulus list.
	typedef enum logic {ROW_ITEM, ROW_DEPTH} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		in_t        item;
		logic [2:0] depth;
		logic       typed;
		out_t       want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the block state used for prediction.
	logic [15:0] palette_shadow [PALETTE_DEPTH];
	bit          palette_written [PALETTE_DEPTH];
	logic [7:0]  shadow_high_byte = '0;
	bit          shadow_high_held = 1'b0;
	logic [2:0]  shadow_depth = DEPTH_DIRECT;

	out_t        expected_pixels [$];
	stim_row_t   stim_rows [$];
	int          mismatch_count = 0;
	int          sent_items = 0;
	int          stall_left = 0;
	bit          quiet = 1'b1;

	palette_pixel_unpacker_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Idle length: mostly none or short, now and then long; none in quiet stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic stim_row_t item_row(logic op, logic [7:0] data, logic [7:0] idx,
			logic [15:0] color, logic typed, logic [15:0] want_color);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.item.op = op;
		r.item.data_byte = data;
		r.item.palette_index = idx;
		r.item.palette_color = color;
		r.depth = '0;
		r.typed = typed;
		r.want.pixel_color = want_color;
		r.want.last_of_byte = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t depth_row(logic [2:0] code);
		stim_row_t r;
		r = '0;
		r.kind = ROW_DEPTH;
		r.depth = code;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Update the shadow state for one accepted transaction and queue the pixels it yields.
	task automatic predict_pixels(input in_t it, input bit keep);
		int   bpp;
		int   count;
		int   idx;
		out_t px;
		if (it.op == OP_PAL_WRITE) begin
			if (it.palette_index < PALETTE_DEPTH) begin
				palette_shadow[it.palette_index] = it.palette_color;
				palette_written[it.palette_index] = 1'b1;
			end
		end else if (shadow_depth >= DEPTH_DIRECT) begin
			if (!shadow_high_held) begin
				shadow_high_byte = it.data_byte;
				shadow_high_held = 1'b1;
			end else begin
				shadow_high_held = 1'b0;
				px.pixel_color = {shadow_high_byte, it.data_byte};
				px.last_of_byte = 1'b1;
				if (keep)
					expected_pixels.push_back(px);
			end
		end else begin
			bpp = 1 << shadow_depth;
			count = 8 / bpp;
			for (int p = 0; p < count; p++) begin
				idx = (it.data_byte >> (p * bpp)) & ((1 << bpp) - 1);
				px.pixel_color = (idx < PALETTE_DEPTH) ? palette_shadow[idx] : 16'h0000;
				px.last_of_byte = (p == count - 1);
				if (keep)
					expected_pixels.push_back(px);
			end
		end
	endtask

	// Present one transaction and hold it until accepted; valid stays up if no gap follows.
	task automatic send_item(input in_t it, input bit typed, input out_t want);
		int gap;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_pixels(it, !typed);
		if (typed)
			expected_pixels.push_back(want);
		sent_items++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write any palette entry that this byte would read before it has been written.
	task automatic fill_palette_for(input logic [7:0] data);
		int  bpp;
		int  idx;
		in_t w;
		if (shadow_depth < DEPTH_DIRECT) begin
			bpp = 1 << shadow_depth;
			for (int p = 0; p < 8 / bpp; p++) begin
				idx = (data >> (p * bpp)) & ((1 << bpp) - 1);
				if (!palette_written[idx]) begin
					w.op = OP_PAL_WRITE;
					w.data_byte = 8'($urandom);
					w.palette_index = 8'(idx);
					w.palette_color = 16'($urandom);
					send_item(w, 1'b0, '0);
				end
			end
		end
	endtask

	// Stop input and wait until every expected pixel is out and the block is idle.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Two-phase register write of the depth code; it also drops a held high byte.
	task automatic write_depth(input logic [2:0] code);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_PIXEL_DEPTH);
		pwdata <= {29'd0, code};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_depth = code;
		shadow_high_held = 1'b0;
	endtask

	// Result checker with random backpressure.
	always @(posedge clk) begin : watch_pixels
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel color %h last %b",
					out_data.pixel_color, out_data.last_of_byte));
			end else begin
				want = expected_pixels.pop_front();
				if (out_data.pixel_color !== want.pixel_color)
					report_mismatch($sformatf("pixel_color expected %h got %h",
						want.pixel_color, out_data.pixel_color));
				if (out_data.last_of_byte !== want.last_of_byte)
					report_mismatch($sformatf("last_of_byte expected %b got %b",
						want.last_of_byte, out_data.last_of_byte));
			end
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	initial begin : stimulus
		stim_row_t row;
		in_t       it;
		int        phase;
		int        burst;
		logic [2:0] code;

		// Directed rows: direct color pairs after reset, palette extremes, every depth.
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hFF, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_PAL_WRITE,  8'h00, 8'h00, 16'h1234, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h00, 8'h00, 16'h0000, 1'b1, 16'hFF00));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h00, 8'hFF, 16'hFFFF, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 16'h00FF));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hAB, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(depth_row(DEPTH_DIRECT));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h12, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h34, 8'h00, 16'h0000, 1'b1, 16'h1234));
		stim_rows.push_back(item_row(OP_PAL_WRITE,  8'hFF, 8'hFF, 16'hFFFF, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_PAL_WRITE,  8'h00, 8'h01, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_PAL_WRITE,  8'h00, 8'h03, 16'hFFFF, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_PAL_WRITE,  8'h00, 8'h0F, 16'h8001, 1'b0, 16'h0000));
		stim_rows.push_back(depth_row(DEPTH_1BPP));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hFF, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h01, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(depth_row(DEPTH_2BPP));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hFF, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(depth_row(DEPTH_4BPP));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hF0, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(depth_row(DEPTH_8BPP));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'hFF, 8'h00, 16'h0000, 1'b1, 16'hFFFF));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h00, 8'h00, 16'h0000, 1'b1, 16'h1234));
		stim_rows.push_back(depth_row(3'd7));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h80, 8'h00, 16'h0000, 1'b0, 16'h0000));
		stim_rows.push_back(item_row(OP_FRAME_BYTE, 8'h01, 8'h00, 16'h0000, 1'b1, 16'h8001));

		// Reset once, then release it on a clock edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_DEPTH) begin
				settle_block();
				write_depth(row.depth);
			end else begin
				send_item(row.item, row.typed, row.want);
			end
		end

		// Random phases: first every depth code in order, then random codes.
		phase = 0;
		while (sent_items < 280) begin
			settle_block();
			quiet = ($urandom_range(0, 3) == 0);
			code = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			write_depth(code);
			burst = $urandom_range(10, 40);
			for (int k = 0; k < burst; k++) begin
				it.data_byte = 8'($urandom);
				it.palette_index = 8'($urandom);
				it.palette_color = 16'($urandom);
				if ($urandom_range(0, 99) < 15) begin
					it.op = OP_PAL_WRITE;
				end else begin
					it.op = OP_FRAME_BYTE;
					fill_palette_for(it.data_byte);
				end
				send_item(it, 1'b0, '0);
			end
			phase++;
		end

		settle_block();
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
